// ===== rtl/core/ccc_pkg.sv =====
package ccc_pkg;

	typedef enum logic [1:0] {
		KIND_TICK = 2'd0,
		KIND_LOAD = 2'd1,
		KIND_READ = 2'd2
	} kind_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] bcd_seconds;
		logic [7:0] bcd_minutes;
		logic [7:0] bcd_hours;
		logic [7:0] bcd_days;
		logic [7:0] bcd_months;
		logic [7:0] bcd_years;
	} in_t;

	typedef struct packed {
		logic [15:0] out_year;
		logic [4:0]  out_month;
		logic [5:0]  out_day;
		logic [5:0]  out_hour;
		logic [6:0]  out_minute;
		logic [6:0]  out_second;
	} out_t;

	// The year is kept together with its remainder modulo 100 and its century
	// modulo 4, which together settle the leap rule without a divider.
	typedef struct packed {
		logic [15:0] year;
		logic [6:0]  year_mod100;
		logic [1:0]  century_mod4;
		logic [4:0]  month;
		logic [5:0]  day;
		logic [5:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} cal_state_t;

	localparam logic [15:0] RST_YEAR = 16'd2011;
	localparam logic [6:0]  RST_YEAR_MOD100 = 7'd11;
	localparam logic [1:0]  RST_CENTURY_MOD4 = 2'd0;
	localparam logic [4:0]  RST_MONTH = 5'd12;
	localparam logic [5:0]  RST_DAY = 6'd13;
	localparam logic [5:0]  RST_HOUR = 6'd12;
	localparam logic [6:0]  RST_MINUTE = 7'd34;
	localparam logic [6:0]  RST_SECOND = 7'd56;

	localparam logic [6:0]  SECS_PER_MIN = 7'd60;
	localparam logic [6:0]  MINS_PER_HOUR = 7'd60;
	localparam logic [5:0]  HOURS_PER_DAY = 6'd24;
	localparam logic [4:0]  MONTHS_PER_YEAR = 5'd12;
	localparam logic [15:0] BASE_YEAR = 16'd2000;
	localparam logic [7:0]  YEARS_PER_CENTURY = 8'd100;
	localparam logic [7:0]  MASK_SEC_MIN = 8'h7F;
	localparam logic [7:0]  MASK_HOUR_DAY = 8'h3F;
	localparam logic [7:0]  MASK_MONTH = 8'h1F;

	function automatic logic [7:0] bcd_decode(input logic [7:0] b);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = {4'd0, b[7:4]};
		lo = {4'd0, b[3:0]};
		return (hi << 3) + (hi << 1) + lo;
	endfunction

	function automatic logic [4:0] month_length(input logic [4:0] month, input logic leap);
		logic [4:0] len;
		unique case (month)
			5'd2: len = leap ? 5'd29 : 5'd28;
			5'd4, 5'd6, 5'd9, 5'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ===== rtl/core/calendar_clock_counter_top.sv =====
// Two register stages: a transaction accepted on req is held in the input register,
// and its result is then registered on rsp.
// Throughput: one transaction per cycle when not stalled by rsp_ready; the result
// register advances whenever it is empty or being taken, and the input register
// also loads while it is empty. Reset: arst_n clears both valid flags and sets
// the time to 2011-12-13 12:34:56.
module calendar_clock_counter_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ccc_pkg::in_t  req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ccc_pkg::out_t rsp
);

	logic                valid_s1;
	ccc_pkg::in_t        item_s1;
	ccc_pkg::cal_state_t state_q;
	ccc_pkg::cal_state_t state_next;
	logic                advance;

	assign advance = !rsp_valid || rsp_ready;
	assign req_ready = !valid_s1 || advance;

	ccc_next u_next (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
			state_q.year <= ccc_pkg::RST_YEAR;
			state_q.year_mod100 <= ccc_pkg::RST_YEAR_MOD100;
			state_q.century_mod4 <= ccc_pkg::RST_CENTURY_MOD4;
			state_q.month <= ccc_pkg::RST_MONTH;
			state_q.day <= ccc_pkg::RST_DAY;
			state_q.hour <= ccc_pkg::RST_HOUR;
			state_q.minute <= ccc_pkg::RST_MINUTE;
			state_q.second <= ccc_pkg::RST_SECOND;
		end else if (advance) begin
			rsp_valid <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp.out_year <= state_next.year;
			rsp.out_month <= state_next.month;
			rsp.out_day <= state_next.day;
			rsp.out_hour <= state_next.hour;
			rsp.out_minute <= state_next.minute;
			rsp.out_second <= state_next.second;
		end
	end

endmodule

// ===== rtl/core/ccc_next.sv =====
module ccc_next (
	input  ccc_pkg::cal_state_t cur,
	input  ccc_pkg::in_t        item,
	output ccc_pkg::cal_state_t nxt
);

	logic [7:0] dec_years;
	logic [6:0] sec_inc;
	logic [6:0] min_inc;
	logic [5:0] hour_inc;
	logic [5:0] day_inc;
	logic [4:0] month_inc;
	logic       leap;
	logic [4:0] mlen;
	logic       carry_s;
	logic       carry_m;
	logic       carry_h;
	logic       carry_d;
	logic       carry_mo;
	logic       year_wrap;
	ccc_pkg::cal_state_t loaded;
	ccc_pkg::cal_state_t ticked;

	always_comb begin
		dec_years = ccc_pkg::bcd_decode(item.bcd_years);
		loaded.second = 7'(ccc_pkg::bcd_decode(item.bcd_seconds & ccc_pkg::MASK_SEC_MIN));
		loaded.minute = 7'(ccc_pkg::bcd_decode(item.bcd_minutes & ccc_pkg::MASK_SEC_MIN));
		loaded.hour = 6'(ccc_pkg::bcd_decode(item.bcd_hours & ccc_pkg::MASK_HOUR_DAY));
		loaded.day = 6'(ccc_pkg::bcd_decode(item.bcd_days & ccc_pkg::MASK_HOUR_DAY));
		loaded.month = 5'(ccc_pkg::bcd_decode(item.bcd_months & ccc_pkg::MASK_MONTH));
		loaded.year = ccc_pkg::BASE_YEAR + {8'd0, dec_years};
		if (dec_years >= ccc_pkg::YEARS_PER_CENTURY) begin
			loaded.year_mod100 = 7'(dec_years - ccc_pkg::YEARS_PER_CENTURY);
			loaded.century_mod4 = 2'd1;
		end else begin
			loaded.year_mod100 = dec_years[6:0];
			loaded.century_mod4 = 2'd0;
		end
	end

	always_comb begin
		sec_inc = cur.second + 7'd1;
		min_inc = cur.minute + 7'd1;
		hour_inc = cur.hour + 6'd1;
		day_inc = cur.day + 6'd1;
		month_inc = cur.month + 5'd1;
		leap = (cur.year[1:0] == 2'd0) &&
			((cur.year_mod100 != 7'd0) || (cur.century_mod4 == 2'd0));
		mlen = ccc_pkg::month_length(cur.month, leap);

		carry_s = sec_inc >= ccc_pkg::SECS_PER_MIN;
		carry_m = carry_s && (min_inc >= ccc_pkg::MINS_PER_HOUR);
		carry_h = carry_m && (hour_inc >= ccc_pkg::HOURS_PER_DAY);
		carry_d = carry_h && (day_inc > {1'b0, mlen});
		carry_mo = carry_d && (month_inc > ccc_pkg::MONTHS_PER_YEAR);
		year_wrap = cur.year == 16'hFFFF;

		ticked = cur;
		ticked.second = carry_s ? 7'd0 : sec_inc;
		if (carry_s) begin
			ticked.minute = carry_m ? 7'd0 : min_inc;
		end
		if (carry_m) begin
			ticked.hour = carry_h ? 6'd0 : hour_inc;
		end
		if (carry_h) begin
			ticked.day = carry_d ? 6'd1 : day_inc;
		end
		if (carry_d) begin
			ticked.month = carry_mo ? 5'd1 : month_inc;
		end
		if (carry_mo) begin
			ticked.year = cur.year + 16'd1;
			if (year_wrap) begin
				ticked.year_mod100 = 7'd0;
				ticked.century_mod4 = 2'd0;
			end else if (cur.year_mod100 == 7'(ccc_pkg::YEARS_PER_CENTURY - 8'd1)) begin
				ticked.year_mod100 = 7'd0;
				ticked.century_mod4 = cur.century_mod4 + 2'd1;
			end else begin
				ticked.year_mod100 = cur.year_mod100 + 7'd1;
			end
		end
	end

	always_comb begin
		unique case (item.kind)
			ccc_pkg::KIND_TICK: nxt = ticked;
			ccc_pkg::KIND_LOAD: nxt = loaded;
			default: nxt = cur;
		endcase
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

class calendar_tracker;
	logic [15:0] cur_year;
	logic [7:0] cur_month;
	logic [7:0] cur_day;
	logic [7:0] cur_hour;
	logic [7:0] cur_minute;
	logic [7:0] cur_second;
	ccc_pkg::out_t pending_times[$];
	int errors;

	function new();
		cur_year = 16'd2011;
		cur_month = 8'd12;
		cur_day = 8'd13;
		cur_hour = 8'd12;
		cur_minute = 8'd34;
		cur_second = 8'd56;
		errors = 0;
	endfunction

	function int month_len(int month, int year);
		bit leap;
		leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
		if (month == 2)
			return leap ? 29 : 28;
		if (month == 4 || month == 6 || month == 9 || month == 11)
			return 30;
		return 31;
	endfunction

	function logic [7:0] unbcd(logic [7:0] b);
		return 8'(b[7:4] * 10 + b[3:0]);
	endfunction

	function void advance_second();
		cur_second = cur_second + 8'd1;
		if (cur_second < 8'd60)
			return;
		cur_second = 8'd0;
		cur_minute = cur_minute + 8'd1;
		if (cur_minute < 8'd60)
			return;
		cur_minute = 8'd0;
		cur_hour = cur_hour + 8'd1;
		if (cur_hour < 8'd24)
			return;
		cur_hour = 8'd0;
		cur_day = cur_day + 8'd1;
		if (int'(cur_day) <= month_len(int'(cur_month), int'(cur_year)))
			return;
		cur_day = 8'd1;
		cur_month = cur_month + 8'd1;
		if (cur_month <= 8'd12)
			return;
		cur_month = 8'd1;
		cur_year = cur_year + 16'd1;
	endfunction

	function void note_request(ccc_pkg::in_t item);
		ccc_pkg::out_t t;
		case (item.kind)
			ccc_pkg::KIND_TICK: begin
				advance_second();
			end
			ccc_pkg::KIND_LOAD: begin
				cur_second = unbcd(item.bcd_seconds & ccc_pkg::MASK_SEC_MIN);
				cur_minute = unbcd(item.bcd_minutes & ccc_pkg::MASK_SEC_MIN);
				cur_hour = unbcd(item.bcd_hours & ccc_pkg::MASK_HOUR_DAY);
				cur_day = unbcd(item.bcd_days & ccc_pkg::MASK_HOUR_DAY);
				cur_month = unbcd(item.bcd_months & ccc_pkg::MASK_MONTH);
				cur_year = ccc_pkg::BASE_YEAR + {8'd0, unbcd(item.bcd_years)};
			end
			default: begin
			end
		endcase
		t.out_year = cur_year;
		t.out_month = cur_month[4:0];
		t.out_day = cur_day[5:0];
		t.out_hour = cur_hour[5:0];
		t.out_minute = cur_minute[6:0];
		t.out_second = cur_second[6:0];
		pending_times.push_back(t);
	endfunction

	function void compare_field(string field, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endfunction

	function void check_time(ccc_pkg::out_t got);
		ccc_pkg::out_t want;
		if (pending_times.size() == 0) begin
			$error("result with no pending transaction: %h", got);
			errors++;
			return;
		end
		want = pending_times.pop_front();
		compare_field("out_year", want.out_year, got.out_year);
		compare_field("out_month", want.out_month, got.out_month);
		compare_field("out_day", want.out_day, got.out_day);
		compare_field("out_hour", want.out_hour, got.out_hour);
		compare_field("out_minute", want.out_minute, got.out_minute);
		compare_field("out_second", want.out_second, got.out_second);
	endfunction
endclass

module tb;
	import ccc_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 750;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_AFTER = 200;
	localparam int HOLD_CYCLES = 300;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	in_t req;
	logic rsp_valid;
	logic rsp_ready;
	out_t rsp;

	calendar_tracker tracker;
	int cycles = 0;
	int checked_count;
	bit send_quiet;

	calendar_clock_counter_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("FAIL calendar_clock_counter_top");
		$finish;
	end

	function logic [7:0] to_bcd(int v);
		return 8'((v / 10) * 16 + (v % 10));
	endfunction

	function in_t make_item(logic [1:0] kind);
		in_t item;
		item.kind = kind;
		item.bcd_seconds = 8'($urandom_range(0, 255));
		item.bcd_minutes = 8'($urandom_range(0, 255));
		item.bcd_hours = 8'($urandom_range(0, 255));
		item.bcd_days = 8'($urandom_range(0, 255));
		item.bcd_months = 8'($urandom_range(0, 255));
		item.bcd_years = 8'($urandom_range(0, 255));
		return item;
	endfunction

	function in_t make_load(logic [7:0] s, logic [7:0] m, logic [7:0] h, logic [7:0] d,
			logic [7:0] mo, logic [7:0] y);
		in_t item;
		item.kind = KIND_LOAD;
		item.bcd_seconds = s;
		item.bcd_minutes = m;
		item.bcd_hours = h;
		item.bcd_days = d;
		item.bcd_months = mo;
		item.bcd_years = y;
		return item;
	endfunction

	// Mostly legal times close to a rollover, with junk in the masked-off bits.
	function in_t random_load();
		int yy;
		int mo;
		int dd;
		int hh;
		int mm;
		int ss;
		if ($urandom_range(0, 9) < 2)
			return make_item(KIND_LOAD);
		yy = $urandom_range(0, 99);
		mo = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
		dd = tracker.month_len(mo, 2000 + yy);
		dd = $urandom_range(0, 1) ? dd : $urandom_range(1, dd);
		hh = $urandom_range(0, 1) ? 23 : $urandom_range(0, 23);
		mm = $urandom_range(0, 1) ? 59 : $urandom_range(0, 59);
		ss = $urandom_range(0, 1) ? $urandom_range(50, 59) : $urandom_range(0, 59);
		return make_load(to_bcd(ss) | 8'($urandom_range(0, 1) << 7),
			to_bcd(mm) | 8'($urandom_range(0, 1) << 7),
			to_bcd(hh) | 8'($urandom_range(0, 3) << 6),
			to_bcd(dd) | 8'($urandom_range(0, 3) << 6),
			to_bcd(mo) | 8'($urandom_range(0, 7) << 5),
			to_bcd(yy));
	endfunction

	task automatic send_item(in_t item);
		int gap;
		if ($urandom_range(0, 29) == 0)
			send_quiet = ~send_quiet;
		gap = send_quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (!req_ready);
		tracker.note_request(item);
		@(negedge clk);
	endtask

	initial begin
		bit quiet;
		int gap;
		rsp_ready = 1'b0;
		checked_count = 0;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				quiet = ~quiet;
			if (checked_count == HOLD_AFTER)
				gap = HOLD_CYCLES;
			else
				gap = quiet ? 0 : $urandom_range(0, 13);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_valid);
			tracker.check_time(rsp);
			checked_count++;
			@(negedge clk);
		end
	end

	initial begin
		int sent;
		int run;
		int r;
		logic [1:0] kind;
		tracker = new();
		send_quiet = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(make_item(KIND_READ));
		send_item(make_item(KIND_UNUSED));
		send_item(make_item(KIND_TICK));
		send_item(make_load(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_item(make_item(KIND_TICK));
		send_item(make_load(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_item(make_item(KIND_TICK));
		send_item(make_load(8'h59, 8'h59, 8'h23, 8'h00, 8'h00, 8'h00));
		send_item(make_item(KIND_TICK));
		send_item(make_load(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99));
		send_item(make_item(KIND_TICK));
		send_item(make_load(8'h59, 8'h59, 8'h23, 8'h28, 8'h02, 8'h00));
		send_item(make_item(KIND_TICK));
		send_item(make_load(8'h59, 8'h59, 8'h23, 8'h29, 8'h02, 8'h00));
		send_item(make_item(KIND_TICK));
		send_item(make_load(8'h59, 8'h59, 8'h23, 8'h28, 8'h02, 8'h23));
		send_item(make_item(KIND_TICK));
		send_item(make_load(8'h59, 8'h59, 8'h23, 8'h30, 8'h04, 8'h24));
		send_item(make_item(KIND_TICK));
		send_item(make_load(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'hFF));
		send_item(make_item(KIND_TICK));
		send_item(make_load(8'hD9, 8'hD9, 8'hE3, 8'hF1, 8'hF2, 8'h45));
		send_item(make_item(KIND_TICK));
		send_item(make_item(KIND_READ));

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) != 0) begin
				send_item(random_load());
				sent++;
			end
			run = $urandom_range(1, 40);
			repeat (run) begin
				r = $urandom_range(0, 99);
				if (r < 85)
					kind = KIND_TICK;
				else if (r < 95)
					kind = KIND_READ;
				else if (r < 98)
					kind = KIND_UNUSED;
				else
					kind = KIND_LOAD;
				send_item(make_item(kind));
				sent++;
			end
		end
		req_valid <= 1'b0;

		while (tracker.pending_times.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0)
			$display("PASS calendar_clock_counter_top");
		else
			$display("FAIL calendar_clock_counter_top");
		$finish;
	end
endmodule
